FILE: rtl/fwu_pkg.sv
// shared types, codes and crc helper for the firmware update receiver
package fwu_pkg;

  // crc-32 constants, msb first
  localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // configuration register indexes
  localparam logic [3:0] REG_UPDATE_COMMAND = 4'd0;
  localparam logic [3:0] REG_IMAGE_BASE     = 4'd1;

  // result action codes
  typedef enum logic [2:0] {
    ACT_BEGIN  = 3'd0,
    ACT_CHUNK  = 3'd1,
    ACT_OK     = 3'd2,
    ACT_CRCERR = 3'd3,
    ACT_ABORT  = 3'd4
  } action_t;

  // byte classes handed from front to back
  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_CHUNK = 2'd1,
    OP_CRC   = 2'd2,
    OP_ABORT = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic [2:0] idx;
    logic       last;
  } op_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] flash_address;
    logic [63:0] chunk_data;
    logic [31:0] image_size;
    logic [31:0] computed_crc;
    logic        error_reported;
  } result_t;

  // one byte through the crc register
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/fwu_fifo.sv
// small first-word-fall-through queue
module fwu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

FILE: rtl/fwu_front.sv
// protocol parser: tracks phase and byte position, classifies each byte
module fwu_front #(
  parameter int CHUNK_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  input  logic           rx_error,
  input  logic [7:0]     update_command,
  output logic           op_push,
  output fwu_pkg::op_t   op
);
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SIZE,
    PH_CHUNK,
    PH_CRC
  } phase_t;

  phase_t      phase;
  logic [2:0]  byte_index;
  logic [31:0] expected_size;
  logic [31:0] written_count;

  logic [31:0] size_next;
  logic [32:0] total;
  logic        chunk_last;

  assign size_next  = expected_size | ({24'h000000, rx_byte} << {byte_index[1:0], 3'b000});
  assign total      = {1'b0, written_count} + 33'(CHUNK_BYTES);
  assign chunk_last = (byte_index == 3'(CHUNK_BYTES-1));

  // classify the accepted byte
  always_comb begin
    op_push = 1'b0;
    op.kind = fwu_pkg::OP_BEGIN;
    op.data = rx_byte;
    op.idx  = byte_index;
    op.last = 1'b0;
    if (accept) begin
      case (phase)
        PH_IDLE: begin
          op_push = (rx_byte == update_command);
        end
        PH_CHUNK: begin
          op_push = 1'b1;
          if (rx_error) begin
            op.kind = fwu_pkg::OP_ABORT;
          end else begin
            op.kind = fwu_pkg::OP_CHUNK;
            op.last = chunk_last;
          end
        end
        PH_CRC: begin
          op_push = 1'b1;
          op.kind = fwu_pkg::OP_CRC;
          op.last = (byte_index == 3'd3);
        end
        default: begin
          op_push = 1'b0;
        end
      endcase
    end
  end

  // phase and position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_index    <= '0;
      expected_size <= '0;
      written_count <= '0;
    end else if (accept) begin
      case (phase)
        PH_IDLE: begin
          if (rx_byte == update_command) begin
            phase         <= PH_SIZE;
            byte_index    <= '0;
            expected_size <= '0;
            written_count <= '0;
          end
        end
        PH_SIZE: begin
          expected_size <= size_next;
          if (byte_index == 3'd3) begin
            byte_index <= '0;
            phase      <= (size_next == '0) ? PH_CRC : PH_CHUNK;
          end else begin
            byte_index <= byte_index + 3'd1;
          end
        end
        PH_CHUNK: begin
          if (rx_error) begin
            phase         <= PH_IDLE;
            byte_index    <= '0;
            expected_size <= '0;
            written_count <= '0;
          end else if (chunk_last) begin
            written_count <= total[31:0];
            byte_index    <= '0;
            if (total >= {1'b0, expected_size}) begin
              phase <= PH_CRC;
            end
          end else begin
            byte_index <= byte_index + 3'd1;
          end
        end
        default: begin
          if (byte_index == 3'd3) begin
            byte_index <= '0;
            phase      <= PH_IDLE;
          end else begin
            byte_index <= byte_index + 3'd1;
          end
        end
      endcase
    end
  end
endmodule

FILE: rtl/fwu_back.sv
// executor: crc, chunk assembly, address generation and result forming
module fwu_back #(
  parameter int CHUNK_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  input  fwu_pkg::op_t      op,
  output logic              op_pop,
  input  logic              res_full,
  output logic              res_push,
  output fwu_pkg::result_t  res,
  input  logic [31:0]       image_base_address
);
  logic [31:0] running_crc;
  logic [31:0] written_count;
  logic [31:0] received_crc;
  logic        chunks_written_flag;
  logic [63:0] chunk_buffer;

  logic        go;
  logic [31:0] crc_next;
  logic [63:0] buf_next;
  logic [31:0] rcrc_next;
  logic [31:0] fin;
  logic        crc_match;

  assign go        = op_valid && !res_full;
  assign op_pop    = go;
  assign crc_next  = fwu_pkg::crc32_byte(running_crc, op.data);
  assign buf_next  = ((op.idx == 3'd0) ? 64'h0 : chunk_buffer)
                   | ({56'h0, op.data} << {op.idx, 3'b000});
  assign rcrc_next = received_crc | ({24'h000000, op.data} << {op.idx[1:0], 3'b000});
  assign fin       = running_crc ^ fwu_pkg::CRC_ONES;
  assign crc_match = (fin == rcrc_next);

  // result for the op at the head of the queue
  always_comb begin
    res          = '0;
    res.action   = fwu_pkg::ACT_BEGIN;
    res_push     = 1'b0;
    case (op.kind)
      fwu_pkg::OP_BEGIN: begin
        res_push = go;
      end
      fwu_pkg::OP_CHUNK: begin
        res_push          = go && op.last;
        res.action        = fwu_pkg::ACT_CHUNK;
        res.flash_address = image_base_address + written_count;
        res.chunk_data    = buf_next;
      end
      fwu_pkg::OP_CRC: begin
        res_push         = go && op.last;
        res.computed_crc = fin;
        if (crc_match) begin
          res.action     = fwu_pkg::ACT_OK;
          res.image_size = written_count;
        end else begin
          res.action         = fwu_pkg::ACT_CRCERR;
          res.error_reported = chunks_written_flag;
        end
      end
      default: begin
        res_push   = go;
        res.action = fwu_pkg::ACT_ABORT;
      end
    endcase
  end

  // chunk assembly buffer
  always_ff @(posedge clk) begin
    if (go && op.kind == fwu_pkg::OP_CHUNK) begin
      chunk_buffer <= buf_next;
    end
  end

  // crc and count state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc         <= fwu_pkg::CRC_ONES;
      written_count       <= '0;
      received_crc        <= '0;
      chunks_written_flag <= 1'b0;
    end else if (go) begin
      case (op.kind)
        fwu_pkg::OP_BEGIN: begin
          running_crc   <= fwu_pkg::CRC_ONES;
          written_count <= '0;
          received_crc  <= '0;
        end
        fwu_pkg::OP_CHUNK: begin
          running_crc <= crc_next;
          if (op.last) begin
            written_count       <= written_count + 32'(CHUNK_BYTES);
            chunks_written_flag <= 1'b1;
          end
        end
        fwu_pkg::OP_CRC: begin
          received_crc <= rcrc_next;
          if (op.last) begin
            chunks_written_flag <= 1'b0;
            if (crc_match) begin
              running_crc   <= fwu_pkg::CRC_ONES;
              written_count <= '0;
              received_crc  <= '0;
            end
          end
        end
        default: begin
          running_crc         <= fwu_pkg::CRC_ONES;
          written_count       <= '0;
          received_crc        <= '0;
          chunks_written_flag <= 1'b0;
        end
      endcase
    end
  end
endmodule

FILE: rtl/firmware_update_receiver_crc32.sv
// top level of the firmware update receiver with crc-32 image check
// a byte's result is registered in the op queue and then in the result queue before it reaches the result ports
// throughput: one byte per cycle while the queues are not full; the byte-wide crc update in the back end sets it
// two-entry queues sit between parser and executor and before the result ports
// reset: synchronous, active high; empties both queues, returns to idle, clears registers but not the chunk buffer
module firmware_update_receiver_crc32 #(
  parameter int CHUNK_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        rx_error,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  action,
  output logic [31:0] flash_address,
  output logic [63:0] chunk_data,
  output logic [31:0] image_size,
  output logic [31:0] computed_crc,
  output logic        error_reported,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int OP_W  = $bits(fwu_pkg::op_t);
  localparam int RES_W = $bits(fwu_pkg::result_t);

  logic [7:0]  update_command;
  logic [31:0] image_base_address;

  logic              accept;
  logic              op_push;
  fwu_pkg::op_t      op_in;
  fwu_pkg::op_t      op_head;
  logic              op_empty;
  logic              op_pop;
  logic              res_push;
  logic              res_full;
  fwu_pkg::result_t  res_in;
  fwu_pkg::result_t  res_head;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      update_command     <= '0;
      image_base_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fwu_pkg::REG_UPDATE_COMMAND: update_command     <= cfg_data[7:0];
        fwu_pkg::REG_IMAGE_BASE:     image_base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  fwu_front #(.CHUNK_BYTES(CHUNK_BYTES)) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .rx_byte        (rx_byte),
    .rx_error       (rx_error),
    .update_command (update_command),
    .op_push        (op_push),
    .op             (op_in)
  );

  fwu_fifo #(.WIDTH(OP_W), .DEPTH(2)) u_op_q (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .din   (op_in),
    .full  (full),
    .pop   (op_pop),
    .dout  (op_head),
    .empty (op_empty)
  );

  fwu_back #(.CHUNK_BYTES(CHUNK_BYTES)) u_back (
    .clk                (clk),
    .rst                (rst),
    .op_valid           (!op_empty),
    .op                 (op_head),
    .op_pop             (op_pop),
    .res_full           (res_full),
    .res_push           (res_push),
    .res                (res_in),
    .image_base_address (image_base_address)
  );

  fwu_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  // result ports
  assign action         = res_head.action;
  assign flash_address  = res_head.flash_address;
  assign chunk_data     = res_head.chunk_data;
  assign image_size     = res_head.image_size;
  assign computed_crc   = res_head.computed_crc;
  assign error_reported = res_head.error_reported;
endmodule

FILE: rtl/fwu_checker.sv
// port-level checker for the firmware update receiver and its bind
module fwu_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  action,
  input logic [31:0] flash_address,
  input logic [63:0] chunk_data,
  input logic [31:0] image_size,
  input logic        error_reported
);
  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // a waiting result carries a known action code
  a_action_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (action <= fwu_pkg::ACT_ABORT))
    else $error("action code out of range");

  // only chunk writes carry an address and data
  a_chunk_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && action != fwu_pkg::ACT_CHUNK)
      |-> (flash_address == 32'h0 && chunk_data == 64'h0))
    else $error("address or data on a non-write result");

  // image size only on success, error flag only on crc error
  a_size_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((action == fwu_pkg::ACT_OK || image_size == 32'h0)
            && (action == fwu_pkg::ACT_CRCERR || error_reported == 1'b0)))
    else $error("size or error flag on wrong result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(action) && $stable(chunk_data)))
    else $error("stalled result changed");
endmodule

bind firmware_update_receiver_crc32 fwu_checker u_fwu_checker (
  .clk            (clk),
  .rst            (rst),
  .empty          (empty),
  .pop            (pop),
  .action         (action),
  .flash_address  (flash_address),
  .chunk_data     (chunk_data),
  .image_size     (image_size),
  .error_reported (error_reported)
);
